### rtl/b64c_pkg.sv
// Shared types, constants and character mapping functions for the Base64 codec.
// No dependencies; every other file of the block but the checker imports this package.
`timescale 1ns / 1ps
`default_nettype none
package b64c_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3D;      // '='
	localparam logic [6:0] IDX_PAD = 7'd64;
	localparam logic [6:0] IDX_INVALID = 7'd65;

	// One unit of work for the back end: up to four result bytes.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;   // index of the final byte of this job
		logic            last;       // job closes a message
		logic            err;        // decode length error result
	} job_t;

	// Map a six-bit value to its character of the standard alphabet.
	function automatic logic [7:0] b64_sym(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26)
			r = 8'(8'd65 + {2'b00, v});
		else if (v < 6'd52)
			r = 8'(8'd71 + {2'b00, v});
		else if (v < 6'd62)
			r = 8'({2'b00, v} - 8'd4);
		else if (v == 6'd62)
			r = 8'h2B;
		else
			r = 8'h2F;
		return r;
	endfunction

	// Map a character to its index; padding and invalid get codes of their own.
	function automatic logic [6:0] b64_index(input logic [7:0] c);
		logic [6:0] r;
		if (c >= 8'h41 && c <= 8'h5A)
			r = 7'(c - 8'h41);
		else if (c >= 8'h61 && c <= 8'h7A)
			r = 7'(c - 8'h47);
		else if (c >= 8'h30 && c <= 8'h39)
			r = 7'(c + 8'd4);
		else if (c == 8'h2B)
			r = 7'd62;
		else if (c == 8'h2F)
			r = 7'd63;
		else if (c == PAD_CHAR)
			r = IDX_PAD;
		else
			r = IDX_INVALID;
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/b64c_front.sv
// Front end of the Base64 codec: holds the mode, gathers group elements and
// turns each complete group or message end into a job. Uses b64c_pkg.
`timescale 1ns / 1ps
`default_nettype none
module b64c_front
	import b64c_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	input  wire logic       in_accept,
	output job_t            job,
	output logic            job_push
);

	logic       mode_q;
	logic [1:0] pos_q;
	logic [7:0] store_q [3];
	logic [1:0] pos_eff;
	logic       group_done;
	logic       job_gen;
	logic [6:0] x0, x1, x2, x3;
	logic       more2, more3;

	// A position of three never arises in encode mode; treat it as zero.
	assign pos_eff = (!mode_q && pos_q == 2'd3) ? 2'd0 : pos_q;
	assign group_done = mode_q ? (pos_eff == 2'd3) : (pos_eff == 2'd2);
	assign job_gen = group_done || in_last;
	assign job_push = in_accept && job_gen;

	assign x0 = b64_index(store_q[0]);
	assign x1 = b64_index(store_q[1]);
	assign x2 = b64_index(store_q[2]);
	assign x3 = b64_index(in_byte);
	assign more2 = !x2[6];
	assign more3 = more2 && !x3[6];

	always_comb begin
		job.bytes = '0;
		job.last_idx = 2'd3;
		job.last = in_last;
		job.err = 1'b0;
		if (!mode_q) begin
			if (group_done) begin
				job.bytes[0] = b64_sym(store_q[0][7:2]);
				job.bytes[1] = b64_sym({store_q[0][1:0], store_q[1][7:4]});
				job.bytes[2] = b64_sym({store_q[1][3:0], in_byte[7:6]});
				job.bytes[3] = b64_sym(in_byte[5:0]);
			end else if (pos_eff == 2'd0) begin
				job.bytes[0] = b64_sym(in_byte[7:2]);
				job.bytes[1] = b64_sym({in_byte[1:0], 4'b0000});
				job.bytes[2] = PAD_CHAR;
				job.bytes[3] = PAD_CHAR;
			end else begin
				job.bytes[0] = b64_sym(store_q[0][7:2]);
				job.bytes[1] = b64_sym({store_q[0][1:0], in_byte[7:4]});
				job.bytes[2] = b64_sym({in_byte[3:0], 2'b00});
				job.bytes[3] = PAD_CHAR;
			end
		end else if (group_done) begin
			job.bytes[0] = 8'({x0, 2'b00}) | 8'(x1 >> 4);
			job.bytes[1] = 8'({x1, 4'b0000}) | 8'(x2 >> 2);
			job.bytes[2] = 8'({x2, 6'b000000}) | 8'(x3);
			job.last_idx = more3 ? 2'd2 : (more2 ? 2'd1 : 2'd0);
		end else begin
			// A message that ends inside a group yields one error result.
			job.last_idx = 2'd0;
			job.last = 1'b1;
			job.err = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			pos_q <= 2'd0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
			pos_q <= 2'd0;
		end else if (in_accept) begin
			pos_q <= job_gen ? 2'd0 : 2'(pos_eff + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && !group_done) begin
			case (pos_eff)
				2'd0: store_q[0] <= in_byte;
				2'd1: store_q[1] <= in_byte;
				default: store_q[2] <= in_byte;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/b64c_queue.sv
// Short first-in first-out queue of jobs between the front and back ends.
// Uses job_t from b64c_pkg; the head is visible without a read delay.
`timescale 1ns / 1ps
`default_nettype none
module b64c_queue
	import b64c_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_data,
	input  wire logic pop,
	output job_t      head,
	output logic      full,
	output logic      not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			if (push && !pop)
				count_q <= CW'(count_q + 1'b1);
			else if (pop && !push)
				count_q <= CW'(count_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

### rtl/b64c_back.sv
// Back end of the Base64 codec: takes jobs from the queue and sends their
// bytes one per cycle, while the output is not stalled, through an output register. Uses b64c_pkg.
`timescale 1ns / 1ps
`default_nettype none
module b64c_back
	import b64c_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  job_t            head,
	input  wire logic       not_empty,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            out_last,
	output logic            out_error
);

	job_t       job_q;
	logic       job_valid_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_error_q;
	logic       out_free;
	logic       emit;
	logic       done;

	assign out_free = !out_valid_q || !out_stall;
	assign emit = job_valid_q && out_free;
	assign done = emit && (idx_q == job_q.last_idx);
	assign pop = not_empty && (!job_valid_q || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				job_valid_q <= 1'b1;
				idx_q <= 2'd0;
			end else begin
				if (done)
					job_valid_q <= 1'b0;
				if (emit)
					idx_q <= 2'(idx_q + 2'd1);
			end
			if (out_free)
				out_valid_q <= job_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= head;
		if (emit) begin
			out_byte_q <= job_q.bytes[idx_q];
			out_last_q <= job_q.last && (idx_q == job_q.last_idx);
			out_error_q <= job_q.err;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_last = out_last_q;
	assign out_error = out_error_q;

endmodule
`default_nettype wire

### rtl/base64_codec_top.sv
// Base64 codec: a job passes from the job queue through the back end's job register to the output register.
// Results leave at one per cycle through the single output register while the receiver does not stall;
// encoding thus takes in three bytes for every four characters it sends, and decoding one character per cycle.
// The job queue (QUEUE_DEPTH entries) lets requests enter while results wait.
// Asynchronous active-low reset clears the mode to encode and empties the group and queue.
`timescale 1ns / 1ps
`default_nettype none
module base64_codec_top
	import b64c_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            out_last,
	output logic            out_error
);

	job_t job;
	job_t head;
	logic job_push;
	logic q_full;
	logic q_not_empty;
	logic q_pop;
	logic in_accept;

	assign in_stall = q_full;
	assign in_accept = in_valid && !q_full;

	b64c_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.in_accept (in_accept),
		.job       (job),
		.job_push  (job_push)
	);

	b64c_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job),
		.pop       (q_pop),
		.head      (head),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	b64c_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.not_empty (q_not_empty),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.out_error (out_error)
	);

endmodule
`default_nettype wire

### rtl/b64c_checker.sv
// Port-level checker for the Base64 codec, bound to base64_codec_top.
// Sees only the top-level ports; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module b64c_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic       out_last,
	input wire logic       out_error
);

	// An error result always closes its message.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_error |-> out_last)
		else $error("error result without last mark");

	// An error result carries a zero byte.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_error |-> out_byte == 8'd0)
		else $error("error result with nonzero byte");

	// The first edge out of reset shows no result.
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result shown straight out of reset");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte)
			&& $stable(out_last) && $stable(out_error))
		else $error("stalled result changed");

endmodule

bind base64_codec_top b64c_checker u_chk (.*);
`default_nettype wire

### sim/tb.sv
// Self-checking testbench for base64_codec_top: encode and decode traffic under random idling.
// Expected output is computed by a behavioral Base64 model kept here; it depends on b64c_pkg.
`timescale 1ns / 1ps
module tb;
	import b64c_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [8*64-1:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       err;
	} conv_result_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;
	logic       out_error;

	conv_result_t converted_due[$];
	int unsigned  in_idle_pct = 0;
	int unsigned  out_idle_pct = 0;
	int           mismatches = 0;
	int           quiet_cycles = 0;
	int           hold_left = 0;
	int           hold_req = 0;
	int           hold_seen = 0;

	// Model state of the codec.
	logic       pred_decode = MODE_ENCODE;
	logic [1:0] pred_pos = 2'd0;
	logic [7:0] pred_store[3];

	base64_codec_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.out_last (out_last),
		.out_error(out_error)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [7:0] index_to_char(input logic [5:0] v);
		return B64_ALPHABET[8*(63 - v) +: 8];
	endfunction

	function automatic logic [6:0] char_to_index(input logic [7:0] c);
		if (c >= "A" && c <= "Z")
			return 7'(c - "A");
		if (c >= "a" && c <= "z")
			return 7'(c - "a" + 8'd26);
		if (c >= "0" && c <= "9")
			return 7'(c - "0" + 8'd52);
		if (c == "+")
			return 7'd62;
		if (c == "/")
			return 7'd63;
		if (c == PAD_CHAR)
			return IDX_PAD;
		return IDX_INVALID;
	endfunction

	task automatic owe_result(input logic [7:0] data, input logic last, input logic err);
		converted_due.push_back('{data: data, last: last, err: err});
	endtask

	// Works out the output caused by one accepted request.
	task automatic convert_item(input logic [7:0] b, input logic last);
		logic [6:0]  x0, x1, x2, x3;
		logic [15:0] w;
		logic        more2, more3;
		logic [7:0]  b0, b1;
		if (pred_decode == MODE_ENCODE) begin
			if (pred_pos == 2'd2) begin
				b0 = pred_store[0];
				b1 = pred_store[1];
				owe_result(index_to_char(b0[7:2]), 1'b0, 1'b0);
				owe_result(index_to_char({b0[1:0], b1[7:4]}), 1'b0, 1'b0);
				owe_result(index_to_char({b1[3:0], b[7:6]}), 1'b0, 1'b0);
				owe_result(index_to_char(b[5:0]), last, 1'b0);
				pred_pos = 2'd0;
			end else begin
				pred_store[pred_pos] = b;
				pred_pos++;
				if (last) begin
					b0 = pred_store[0];
					owe_result(index_to_char(b0[7:2]), 1'b0, 1'b0);
					if (pred_pos == 2'd1) begin
						owe_result(index_to_char({b0[1:0], 4'b0000}), 1'b0, 1'b0);
						owe_result(PAD_CHAR, 1'b0, 1'b0);
					end else begin
						b1 = pred_store[1];
						owe_result(index_to_char({b0[1:0], b1[7:4]}), 1'b0, 1'b0);
						owe_result(index_to_char({b1[3:0], 2'b00}), 1'b0, 1'b0);
					end
					owe_result(PAD_CHAR, 1'b1, 1'b0);
					pred_pos = 2'd0;
				end
			end
		end else if (pred_pos == 2'd3) begin
			x0 = char_to_index(pred_store[0]);
			x1 = char_to_index(pred_store[1]);
			x2 = char_to_index(pred_store[2]);
			x3 = char_to_index(b);
			more2 = x2 < IDX_PAD;
			more3 = more2 && (x3 < IDX_PAD);
			// Pad and invalid indexes still feed the shifts; only the low byte survives.
			w = ({9'd0, x0} << 2) | ({9'd0, x1} >> 4);
			owe_result(w[7:0], more2 ? 1'b0 : last, 1'b0);
			if (more2) begin
				w = ({9'd0, x1} << 4) | ({9'd0, x2} >> 2);
				owe_result(w[7:0], more3 ? 1'b0 : last, 1'b0);
				if (more3) begin
					w = ({9'd0, x2} << 6) | {9'd0, x3};
					owe_result(w[7:0], last, 1'b0);
				end
			end
			pred_pos = 2'd0;
		end else begin
			pred_store[pred_pos] = b;
			pred_pos++;
			if (last) begin
				owe_result(8'h00, 1'b1, 1'b1);
				pred_pos = 2'd0;
			end
		end
	endtask

	// Offers one request and returns right after the edge that accepts it.
	task automatic send_item(input logic [7:0] b, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_byte = b;
		in_last = last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		convert_item(b, last);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (converted_due.size() != 0)
			@(posedge clk);
		// A partial group leaves no output, so give the block time to finish with it.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic mode);
		drain();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = mode;
		@(negedge clk);
		cfg_we = 1'b0;
		pred_decode = mode;
		pred_pos = 2'd0;
	endtask

	task automatic send_raw_message(input int len);
		for (int i = 0; i < len; i++)
			send_item(8'($urandom_range(255)), i == len - 1);
	endtask

	// Well-formed text: whole groups, the final one padded with zero to two pad characters.
	task automatic send_b64_message(input int groups);
		int         pad;
		logic [7:0] c;
		pad = $urandom_range(2);
		for (int g = 0; g < groups; g++) begin
			for (int k = 0; k < 4; k++) begin
				if (g == groups - 1 && k >= 4 - pad)
					c = PAD_CHAR;
				else
					c = index_to_char(6'($urandom_range(63)));
				send_item(c, g == groups - 1 && k == 3);
			end
		end
	endtask

	// Text of any length: valid characters, mixed with stray bytes and pad characters when any_byte is set.
	task automatic send_char_noise(input int len, input bit any_byte);
		logic [7:0] c;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(3))
				0: c = any_byte ? 8'($urandom_range(255))
					: index_to_char(6'($urandom_range(63)));
				1: c = any_byte ? PAD_CHAR : index_to_char(6'($urandom_range(63)));
				default: c = index_to_char(6'($urandom_range(63)));
			endcase
			send_item(c, i == len - 1);
		end
	endtask

	task automatic test_encode_cases();
		write_mode(MODE_ENCODE);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'hFF, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(8'h01, 1'b1);
		send_item(8'h12, 1'b0);
		send_item(8'h34, 1'b0);
		send_item(8'h56, 1'b1);
		// A mode write in the middle of a group throws the held byte away.
		send_item(8'h41, 1'b0);
		write_mode(MODE_ENCODE);
		send_item(8'h7F, 1'b1);
	endtask

	task automatic test_decode_cases();
		write_mode(MODE_DECODE);
		send_item("a", 1'b0);
		send_item("z", 1'b0);
		send_item("+", 1'b0);
		send_item("/", 1'b0);
		send_item("T", 1'b0);
		send_item("Q", 1'b0);
		send_item(PAD_CHAR, 1'b0);
		send_item(PAD_CHAR, 1'b1);
		// Invalid characters in the third or fourth place stop the later bytes of the group.
		send_item("*", 1'b0);
		send_item(PAD_CHAR, 1'b0);
		send_item("9", 1'b0);
		send_item(8'hFF, 1'b1);
		// A message that ends inside a group gives the error result.
		send_item("0", 1'b0);
		send_item("B", 1'b1);
	endtask

	task automatic test_random_traffic(input int unsigned sender_pct,
		input int unsigned receiver_pct);
		int len;
		int tally;
		in_idle_pct = sender_pct;
		out_idle_pct = receiver_pct;
		repeat (3) begin
			write_mode(MODE_ENCODE);
			tally = 0;
			while (tally < 15) begin
				len = $urandom_range(1, 8);
				send_raw_message(len);
				tally += len;
			end
			write_mode(MODE_DECODE);
			tally = 0;
			while (tally < 15) begin
				case ($urandom_range(9))
					7: begin
						len = $urandom_range(1, 12);
						send_char_noise(len, 1'b1);
					end
					8, 9: begin
						len = 4 * $urandom_range(0, 2) + $urandom_range(1, 3);
						send_char_noise(len, 1'b0);
					end
					default: begin
						len = 4 * $urandom_range(1, 4);
						send_b64_message(len / 4);
					end
				endcase
				tally += len;
			end
		end
	endtask

	task automatic test_backpressure();
		in_idle_pct = 0;
		out_idle_pct = 0;
		write_mode(MODE_ENCODE);
		hold_req++;
		send_raw_message(24);
		drain();
	endtask

	// Receiver side: random stalls, or a long hold-off when a test asks for one.
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_left = HOLD_CYCLES;
			hold_seen = hold_req;
		end
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = $urandom_range(99) < out_idle_pct;
		end
	end

	always @(posedge clk) begin : result_check
		conv_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (converted_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected output: byte %02h last %0b error %0b",
						out_byte, out_last, out_error);
			end else begin
				want = converted_due.pop_front();
				if (out_byte !== want.data || out_last !== want.last
					|| out_error !== want.err) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"Mismatch: expected byte %02h last %0b error %0b,",
							" got byte %02h last %0b error %0b"},
							want.data, want.last, want.err,
							out_byte, out_last, out_error);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no request or output moved for %0d cycles", WATCHDOG_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_encode_cases();
		test_decode_cases();
		test_backpressure();
		test_random_traffic(12, 51);
		test_random_traffic(51, 12);
		test_random_traffic(0, 0);
		drain();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### base64_codec_top.f
rtl/b64c_pkg.sv
rtl/b64c_front.sv
rtl/b64c_queue.sv
rtl/b64c_back.sv
rtl/base64_codec_top.sv
rtl/b64c_checker.sv
sim/tb.sv
